/* sv/rotate_point_about_axis_unit_defines.svh */
// assertion macros for the rotate point about axis unit
`ifndef ROTATE_POINT_ABOUT_AXIS_UNIT_DEFINES_SVH
`define ROTATE_POINT_ABOUT_AXIS_UNIT_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define RPA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpa check failed");

// next-cycle implication, checked only out of reset
`define RPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpa check failed");

`endif

/* sv/rpa_pkg.sv */
// shared types, constants and tables of the rotate point about axis unit
package rpa_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W = 2 * COORD_FRAC_BITS;
  localparam int CW = 34;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;
  localparam int MID_PW = $clog2(MID_DEPTH);
  localparam int OUT_PW = $clog2(OUT_DEPTH);

  localparam logic signed [CW-1:0] ONE_Q30 = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'sd652032874);
  localparam logic [1:0] QUAD_1 = 2'b01;
  localparam logic [1:0] QUAD_2 = 2'b10;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dz;
  } carry_t;

  typedef logic signed [31:0] entry_t;

  typedef struct packed {
    entry_t [8:0] m;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dz;
  } mid_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rz;
    logic clip;
  } out_item_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic signed [CW-1:0] atan_turn(input int idx);
    logic [29:0] v;
    begin
      case (idx)
        0: v = 30'd536870912;
        1: v = 30'd316933406;
        2: v = 30'd167458907;
        3: v = 30'd85004756;
        4: v = 30'd42667331;
        5: v = 30'd21354465;
        6: v = 30'd10679838;
        7: v = 30'd5341269;
        8: v = 30'd2670163;
        9: v = 30'd1335087;
        10: v = 30'd667544;
        11: v = 30'd333772;
        12: v = 30'd166886;
        13: v = 30'd83443;
        14: v = 30'd41722;
        15: v = 30'd20861;
        16: v = 30'd10430;
        17: v = 30'd5215;
        18: v = 30'd2608;
        19: v = 30'd1304;
        20: v = 30'd652;
        21: v = 30'd326;
        22: v = 30'd163;
        23: v = 30'd81;
        default: v = 30'd0;
      endcase
      atan_turn = $signed({4'b0000, v});
    end
  endfunction

endpackage

/* sv/rpa_front.sv */
// front part: angle reduction, cordic and rodrigues matrix build
module rpa_front
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [15:0] in_turn_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [COORD_W-1:0] in_pivot_x,
  input  logic signed [COORD_W-1:0] in_pivot_y,
  input  logic signed [COORD_W-1:0] in_pivot_z,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  q_stat_t mid_stat,
  output logic mid_push,
  output mid_item_t mid_item
);

  logic adv;
  logic flip;
  logic [15:0] ang;

  logic signed [CW-1:0] cx_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy_r [0:CORDIC_STEPS];
  logic signed [CW-1:0] cz_r [0:CORDIC_STEPS];
  carry_t cc_r [0:CORDIC_STEPS];
  logic cv_r [0:CORDIC_STEPS];

  // m0: cos, sin, one minus cos, axis products
  logic m0_v_r;
  carry_t m0_c_r;
  logic signed [CW-1:0] m0_cos_r, m0_sin_r, m0_omc_r;
  logic signed [31:0] m0_aa_r [0:5];
  logic signed [CW-1:0] cos_nxt, sin_nxt;

  // m1: outer and sine terms
  logic m1_v_r;
  carry_t m1_c_r;
  logic signed [CW-1:0] m1_cos_r;
  logic signed [35:0] m1_out_r [0:5];
  logic signed [35:0] m1_sin_r [0:2];
  logic signed [65:0] outer_prod [0:5];
  logic signed [49:0] sin_prod [0:2];
  logic signed [15:0] sin_axis [0:2];

  // m2: rounded matrix entries
  logic m2_v_r;
  mid_item_t m2_r;
  logic signed [36:0] ent_v [0:8];
  entry_t ent_q [0:8];
  logic signed [36:0] cos_e;

  assign adv = !(m2_v_r && mid_stat.full);
  assign in_full = !adv;
  assign mid_push = m2_v_r && adv;
  assign mid_item = m2_r;

  assign flip = (in_turn_angle[15:14] == QUAD_1) || (in_turn_angle[15:14] == QUAD_2);
  assign ang = in_turn_angle ^ {flip, 15'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= in_push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[0] <= CORDIC_X0;
      cy_r[0] <= '0;
      cz_r[0] <= $signed({{(CW-32){ang[15]}}, ang, 16'd0});
      cc_r[0].flip <= flip;
      cc_r[0].ax <= in_axis_x;
      cc_r[0].ay <= in_axis_y;
      cc_r[0].az <= in_axis_z;
      cc_r[0].px <= in_pivot_x;
      cc_r[0].py <= in_pivot_y;
      cc_r[0].pz <= in_pivot_z;
      cc_r[0].dx <= (COORD_W+1)'(in_point_x) - (COORD_W+1)'(in_pivot_x);
      cc_r[0].dy <= (COORD_W+1)'(in_point_y) - (COORD_W+1)'(in_pivot_y);
      cc_r[0].dz <= (COORD_W+1)'(in_point_z) - (COORD_W+1)'(in_pivot_z);
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [CW-1:0] xs, ys;
    assign xs = cx_r[k] >>> k;
    assign ys = cy_r[k] >>> k;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k+1] <= 1'b0;
      end else if (adv) begin
        cv_r[k+1] <= cv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cc_r[k+1] <= cc_r[k];
        if (!cz_r[k][CW-1]) begin
          cx_r[k+1] <= cx_r[k] - ys;
          cy_r[k+1] <= cy_r[k] + xs;
          cz_r[k+1] <= cz_r[k] - atan_turn(k);
        end else begin
          cx_r[k+1] <= cx_r[k] + ys;
          cy_r[k+1] <= cy_r[k] - xs;
          cz_r[k+1] <= cz_r[k] + atan_turn(k);
        end
      end
    end
  end

  assign cos_nxt = cc_r[CORDIC_STEPS].flip ? -cx_r[CORDIC_STEPS] : cx_r[CORDIC_STEPS];
  assign sin_nxt = cc_r[CORDIC_STEPS].flip ? -cy_r[CORDIC_STEPS] : cy_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_v_r <= 1'b0;
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
    end else if (adv) begin
      m0_v_r <= cv_r[CORDIC_STEPS];
      m1_v_r <= m0_v_r;
      m2_v_r <= m1_v_r;
    end
  end

  // axis products in order xx, xy, xz, yy, yz, zz
  always_ff @(posedge clk) begin
    if (adv) begin
      m0_c_r <= cc_r[CORDIC_STEPS];
      m0_cos_r <= cos_nxt;
      m0_sin_r <= sin_nxt;
      m0_omc_r <= ONE_Q30 - cos_nxt;
      m0_aa_r[0] <= cc_r[CORDIC_STEPS].ax * cc_r[CORDIC_STEPS].ax;
      m0_aa_r[1] <= cc_r[CORDIC_STEPS].ax * cc_r[CORDIC_STEPS].ay;
      m0_aa_r[2] <= cc_r[CORDIC_STEPS].ax * cc_r[CORDIC_STEPS].az;
      m0_aa_r[3] <= cc_r[CORDIC_STEPS].ay * cc_r[CORDIC_STEPS].ay;
      m0_aa_r[4] <= cc_r[CORDIC_STEPS].ay * cc_r[CORDIC_STEPS].az;
      m0_aa_r[5] <= cc_r[CORDIC_STEPS].az * cc_r[CORDIC_STEPS].az;
    end
  end

  assign sin_axis[0] = m0_c_r.ax;
  assign sin_axis[1] = m0_c_r.ay;
  assign sin_axis[2] = m0_c_r.az;

  for (genvar j = 0; j < 6; j++) begin : g_outer
    assign outer_prod[j] = 66'(m0_aa_r[j]) * 66'(m0_omc_r);
  end

  for (genvar j = 0; j < 3; j++) begin : g_sin
    assign sin_prod[j] = 50'(sin_axis[j]) * 50'(m0_sin_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_c_r <= m0_c_r;
      m1_cos_r <= m0_cos_r;
      for (int j = 0; j < 6; j++) begin
        m1_out_r[j] <= outer_prod[j][63:28];
      end
      for (int j = 0; j < 3; j++) begin
        m1_sin_r[j] <= sin_prod[j][49:14];
      end
    end
  end

  // sine terms: 0 x, 1 y, 2 z
  assign cos_e = 37'(m1_cos_r);
  assign ent_v[0] = cos_e + 37'(m1_out_r[0]);
  assign ent_v[1] = 37'(m1_out_r[1]) - 37'(m1_sin_r[2]);
  assign ent_v[2] = 37'(m1_out_r[2]) + 37'(m1_sin_r[1]);
  assign ent_v[3] = 37'(m1_out_r[1]) + 37'(m1_sin_r[2]);
  assign ent_v[4] = cos_e + 37'(m1_out_r[3]);
  assign ent_v[5] = 37'(m1_out_r[4]) - 37'(m1_sin_r[0]);
  assign ent_v[6] = 37'(m1_out_r[2]) - 37'(m1_sin_r[1]);
  assign ent_v[7] = 37'(m1_out_r[4]) + 37'(m1_sin_r[0]);
  assign ent_v[8] = cos_e + 37'(m1_out_r[5]);

  for (genvar j = 0; j < 9; j++) begin : g_round
    logic signed [36:0] rv;
    assign rv = ent_v[j] + 37'sd32;
    assign ent_q[j] = 32'($signed(rv[36:6]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 9; j++) begin
        m2_r.m[j] <= ent_q[j];
      end
      m2_r.px <= m1_c_r.px;
      m2_r.py <= m1_c_r.py;
      m2_r.pz <= m1_c_r.pz;
      m2_r.dx <= m1_c_r.dx;
      m2_r.dy <= m1_c_r.dy;
      m2_r.dz <= m1_c_r.dz;
    end
  end

endmodule

/* sv/rpa_mid_queue.sv */
// short queue of matrix items between the front and back parts
module rpa_mid_queue
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  mid_item_t wr_item,
  input  logic pop,
  output mid_item_t rd_item,
  output q_stat_t stat
);

  mid_item_t mem_r [0:MID_DEPTH-1];
  logic [MID_PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [MID_PW:0] count_r;

  assign rd_item = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full = (count_r == (MID_PW+1)'(MID_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10: count_r <= count_r + 1'b1;
        2'b01: count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* sv/rpa_back.sv */
// back part: matrix times offset, rounding, pivot add, saturation and result queue
module rpa_back
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  mid_item_t mid_item,
  input  q_stat_t mid_stat,
  output logic mid_pop,
  input  logic out_pop,
  output logic out_empty,
  output logic signed [COORD_W-1:0] out_rotated_x,
  output logic signed [COORD_W-1:0] out_rotated_y,
  output logic signed [COORD_W-1:0] out_rotated_z,
  output logic out_clipped
);

  localparam int PW = 2 * COORD_W + 1;
  localparam int SW = PW + 2;
  localparam int RW = SW - 24 + 1;
  localparam logic signed [RW-1:0] SAT_MAX = RW'({1'b0, {(COORD_W-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_MIN = -SAT_MAX - RW'(1);

  logic adv;
  logic oq_full;
  logic oq_push;

  logic b0_v_r, b1_v_r, b2_v_r;
  logic signed [PW-1:0] b0_p_r [0:8];
  logic signed [COORD_W-1:0] b0_piv_r [0:2], b1_piv_r [0:2];
  logic signed [SW-1:0] b1_s_r [0:2];
  out_item_t b2_r;

  logic signed [COORD_W:0] dvec [0:2];
  logic signed [COORD_W-1:0] piv [0:2];
  logic signed [RW-1:0] res [0:2];
  logic [2:0] hi, lo;
  logic signed [COORD_W-1:0] sat [0:2];

  out_item_t oq_r [0:OUT_DEPTH-1];
  logic [OUT_PW-1:0] owr_r, ord_r;
  logic [OUT_PW:0] ocnt_r;
  out_item_t head;

  assign adv = !(b2_v_r && oq_full);
  assign mid_pop = adv && !mid_stat.empty;
  assign oq_push = adv && b2_v_r;

  assign dvec[0] = mid_item.dx;
  assign dvec[1] = mid_item.dy;
  assign dvec[2] = mid_item.dz;
  assign piv[0] = mid_item.px;
  assign piv[1] = mid_item.py;
  assign piv[2] = mid_item.pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r <= 1'b0;
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r <= !mid_stat.empty;
      b1_v_r <= b0_v_r;
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          b0_p_r[3*r+c] <= PW'(mid_item.m[3*r+c]) * PW'(dvec[c]);
        end
        b0_piv_r[r] <= piv[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        b1_s_r[r] <= SW'(b0_p_r[3*r]) + SW'(b0_p_r[3*r+1]) + SW'(b0_p_r[3*r+2]);
        b1_piv_r[r] <= b0_piv_r[r];
      end
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [SW-1:0] rs;
    assign rs = b1_s_r[r] + SW'(64'sd8388608);
    assign res[r] = RW'($signed(rs[SW-1:24])) + RW'(b1_piv_r[r]);
    assign hi[r] = res[r] > SAT_MAX;
    assign lo[r] = res[r] < SAT_MIN;
    assign sat[r] = hi[r] ? SAT_MAX[COORD_W-1:0] :
                    lo[r] ? SAT_MIN[COORD_W-1:0] : res[r][COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_r.rx <= sat[0];
      b2_r.ry <= sat[1];
      b2_r.rz <= sat[2];
      b2_r.clip <= |(hi | lo);
    end
  end

  // result queue
  assign oq_full = (ocnt_r == (OUT_PW+1)'(OUT_DEPTH));
  assign out_empty = (ocnt_r == '0);
  assign head = oq_r[ord_r];
  assign out_rotated_x = head.rx;
  assign out_rotated_y = head.ry;
  assign out_rotated_z = head.rz;
  assign out_clipped = head.clip;

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[owr_r] <= b2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r <= '0;
      ord_r <= '0;
      ocnt_r <= '0;
    end else begin
      if (oq_push) begin
        owr_r <= owr_r + 1'b1;
      end
      if (out_pop && !out_empty) begin
        ord_r <= ord_r + 1'b1;
      end
      case ({oq_push, out_pop && !out_empty})
        2'b10: ocnt_r <= ocnt_r + 1'b1;
        2'b01: ocnt_r <= ocnt_r - 1'b1;
        default: ocnt_r <= ocnt_r;
      endcase
    end
  end

endmodule

/* sv/rotate_point_about_axis_unit.sv */
// top level of the rotate point about axis unit
// throughput: one beat per cycle while no queue is full; set by the front pipeline
// (1 + 16 cordic + 3 matrix stages) feeding a 4-entry queue, and the 3-stage back
// product pipeline
// reset: synchronous, active low; empties all queues and pipelines, no clearing pass
module rotate_point_about_axis_unit
  import rpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [15:0] in_turn_angle,
  input  logic signed [15:0] in_axis_x,
  input  logic signed [15:0] in_axis_y,
  input  logic signed [15:0] in_axis_z,
  input  logic signed [COORD_W-1:0] in_pivot_x,
  input  logic signed [COORD_W-1:0] in_pivot_y,
  input  logic signed [COORD_W-1:0] in_pivot_z,
  input  logic signed [COORD_W-1:0] in_point_x,
  input  logic signed [COORD_W-1:0] in_point_y,
  input  logic signed [COORD_W-1:0] in_point_z,
  input  logic out_pop,
  output logic out_empty,
  output logic signed [COORD_W-1:0] out_rotated_x,
  output logic signed [COORD_W-1:0] out_rotated_y,
  output logic signed [COORD_W-1:0] out_rotated_z,
  output logic out_clipped
);

  q_stat_t mid_stat;
  logic mid_push, mid_pop;
  mid_item_t mid_wr, mid_rd;

  rpa_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_turn_angle(in_turn_angle),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_pivot_x(in_pivot_x), .in_pivot_y(in_pivot_y), .in_pivot_z(in_pivot_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .mid_stat(mid_stat), .mid_push(mid_push), .mid_item(mid_wr)
  );

  rpa_mid_queue u_mid (
    .clk(clk), .rst_n(rst_n),
    .push(mid_push), .wr_item(mid_wr),
    .pop(mid_pop), .rd_item(mid_rd), .stat(mid_stat)
  );

  rpa_back u_back (
    .clk(clk), .rst_n(rst_n),
    .mid_item(mid_rd), .mid_stat(mid_stat), .mid_pop(mid_pop),
    .out_pop(out_pop), .out_empty(out_empty),
    .out_rotated_x(out_rotated_x), .out_rotated_y(out_rotated_y),
    .out_rotated_z(out_rotated_z), .out_clipped(out_clipped)
  );

endmodule

/* sv/rpa_checker.sv */
// port checker for the rotate point about axis unit, with its bind
`include "rotate_point_about_axis_unit_defines.svh"

module rpa_checker
  import rpa_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_push,
  input logic in_full,
  input logic [15:0] in_turn_angle,
  input logic signed [15:0] in_axis_x,
  input logic signed [15:0] in_axis_y,
  input logic signed [15:0] in_axis_z,
  input logic signed [COORD_W-1:0] in_pivot_x,
  input logic signed [COORD_W-1:0] in_pivot_y,
  input logic signed [COORD_W-1:0] in_pivot_z,
  input logic signed [COORD_W-1:0] in_point_x,
  input logic signed [COORD_W-1:0] in_point_y,
  input logic signed [COORD_W-1:0] in_point_z,
  input logic out_pop,
  input logic out_empty,
  input logic signed [COORD_W-1:0] out_rotated_x,
  input logic signed [COORD_W-1:0] out_rotated_y,
  input logic signed [COORD_W-1:0] out_rotated_z,
  input logic out_clipped
);

  localparam logic [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};

  // a clipped beat carries at least one saturated coordinate
  `RPA_ASSERT_IMPL(a_clip_sat, !out_empty && out_clipped, out_rotated_x == CMAX || out_rotated_x == CMIN || out_rotated_y == CMAX || out_rotated_y == CMIN || out_rotated_z == CMAX || out_rotated_z == CMIN)
  // straight out of reset nothing waits and input is open
  `RPA_ASSERT_IMPL(a_reset_state, $past(!rst_n), !in_full && out_empty)
  // a waiting beat stays until taken
  `RPA_ASSERT_NEXT(a_hold_valid, !out_empty && !out_pop, !out_empty)
  `RPA_ASSERT_NEXT(a_hold_data, !out_empty && !out_pop, $stable(out_rotated_x) && $stable(out_rotated_y) && $stable(out_rotated_z) && $stable(out_clipped))

endmodule

bind rotate_point_about_axis_unit rpa_checker u_rpa_checker (.*);
